/* rtl/core/button_click_long_press_repeat_macros.svh */
// Assertion macros for the button click, long-press and repeat detector.
// Used by the top level only; no other dependencies.
`ifndef BUTTON_CLICK_LONG_PRESS_REPEAT_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_REPEAT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCLPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// The expression must never be true outside reset.
`define BCLPR_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* rtl/core/bclpr_pkg.sv */
// Shared types, constants and helper functions for the button detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bclpr_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_W     = 32;
  localparam int THR_W     = 16;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] PRESS_MAX = {CNT_W{1'b1}};

  localparam logic [THR_W-1:0] CLICK_WINDOW_RST = 16'd300;
  localparam logic [THR_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [THR_W-1:0] REPEAT_RST       = 16'd100;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED      = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_LONG_PRESS   = 2'd2,
    REG_REPEAT       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             enabled;
    logic [THR_W-1:0] click_window_ms;
    logic [THR_W-1:0] long_press_ms;
    logic [THR_W-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic             level;
    logic [NOW_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic             changed;
    logic             pressed;
    logic [CNT_W-1:0] press_count;
    logic [CNT_W-1:0] click_total;
    logic             long_flag;
    logic             repeat_flag;
  } result_t;

  function automatic time_t to_time(logic [NOW_W-1:0] v);
    logic [TIME_BITS+NOW_W-1:0] ext;
    ext = {{TIME_BITS{1'b0}}, v};
    return ext[TIME_BITS-1:0];
  endfunction

  function automatic logic exceeds(time_t d, logic [THR_W-1:0] thr);
    logic [TIME_BITS+THR_W-1:0] a;
    logic [TIME_BITS+THR_W-1:0] b;
    a = {{THR_W{1'b0}}, d};
    b = {{TIME_BITS{1'b0}}, thr};
    return a > b;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/button_click_long_press_repeat.sv */
// Top level of the button multi-click, long-press and repeat detector.
// Depends on bclpr_pkg, bclpr_cfg, bclpr_core and the assertion macro header.
//
// Usage: each request on the in_ channel is one sample of the active-low
// button level with the current millisecond time. Each request yields exactly
// one result on the out_ channel, in order. A request is taken when in_valid
// is high and in_stall is low; a result is taken when out_valid is high and
// out_stall is low. Configuration is written over the cfg_ channel, which is
// always ready; the user must write it only while no request is in flight;
// the block does not enforce this. A sample passes the input register, then
// the state update and the result register. Throughput is one sample per
// cycle while out_stall is low, set by the state update loop. in_stall rises
// only while both registers are full and out_stall is high; the stalled
// result holds. Synchronous reset empties both registers, restores the
// register defaults (enabled, 300, 1000 and 100 ms) and releases the detector.
`default_nettype none
`include "button_click_long_press_repeat_macros.svh"

module button_click_long_press_repeat (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output wire logic                            in_stall,
  input  wire logic                            in_level,
  input  wire logic [31:0]                     in_now_ms,
  output wire logic                            out_valid,
  input  wire logic                            out_stall,
  output wire logic                            out_changed,
  output wire logic                            out_pressed,
  output wire logic [7:0]                      out_press_count,
  output wire logic [7:0]                      out_click_total,
  output wire logic                            out_long_flag,
  output wire logic                            out_repeat_flag,
  input  wire logic                            cfg_valid,
  output wire logic                            cfg_ready,
  input  wire logic [bclpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  logic                in_vld_r, in_vld_nxt;
  bclpr_pkg::sample_t  in_smp_r;
  logic                out_vld_r, out_vld_nxt;
  bclpr_pkg::result_t  out_res_r;
  bclpr_pkg::result_t  res;
  bclpr_pkg::cfg_t     cfg;
  logic                in_take;
  logic                adv;

  assign cfg_ready = 1'b1;

  bclpr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bclpr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .smp   (in_smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = in_take || (in_vld_r && !adv);
    out_vld_nxt = adv || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_smp_r.level  <= in_level;
      in_smp_r.now_ms <= in_now_ms;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_changed     = out_res_r.changed;
  assign out_pressed     = out_res_r.pressed;
  assign out_press_count = out_res_r.press_count;
  assign out_click_total = out_res_r.click_total;
  assign out_long_flag   = out_res_r.long_flag;
  assign out_repeat_flag = out_res_r.repeat_flag;

  `BCLPR_ASSERT_IMPLY(a_click_changed, clk, rst_n, out_valid && (out_click_total != 8'd0), out_changed)
  `BCLPR_ASSERT_IMPLY(a_repeat_long, clk, rst_n, out_valid && out_repeat_flag, out_long_flag)
  `BCLPR_ASSERT_IMPLY(a_long_held, clk, rst_n, out_valid && out_long_flag, out_pressed)
  `BCLPR_ASSERT_NEVER(a_stall_empty, clk, rst_n, in_stall && !out_valid)

endmodule

`default_nettype wire

/* rtl/core/bclpr_cfg.sv */
// Configuration register file of the button detector.
// Depends on bclpr_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module bclpr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [bclpr_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [bclpr_pkg::THR_W-1:0]     wr_data,
  output bclpr_pkg::cfg_t                      cfg
);

  bclpr_pkg::cfg_t cfg_r;
  bclpr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (bclpr_pkg::cfg_reg_t'(wr_index))
        bclpr_pkg::REG_ENABLED:      cfg_nxt.enabled         = wr_data[0];
        bclpr_pkg::REG_CLICK_WINDOW: cfg_nxt.click_window_ms = wr_data;
        bclpr_pkg::REG_LONG_PRESS:   cfg_nxt.long_press_ms   = wr_data;
        bclpr_pkg::REG_REPEAT:       cfg_nxt.repeat_ms       = wr_data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b1;
      cfg_r.click_window_ms <= bclpr_pkg::CLICK_WINDOW_RST;
      cfg_r.long_press_ms   <= bclpr_pkg::LONG_PRESS_RST;
      cfg_r.repeat_ms       <= bclpr_pkg::REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/bclpr_core.sv */
// Detector state and its single-pass update for one registered sample.
// Depends on bclpr_pkg for types and the wrapping time helpers.
`default_nettype none

module bclpr_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire bclpr_pkg::sample_t smp,
  input  wire bclpr_pkg::cfg_t    cfg,
  output bclpr_pkg::result_t res
);

  logic                        last_level_r, last_level_nxt;
  bclpr_pkg::time_t            hold_start_r, hold_start_nxt;
  bclpr_pkg::time_t            window_start_r, window_start_nxt;
  logic [bclpr_pkg::CNT_W-1:0] presses_r, presses_nxt;
  logic                        long_r, long_nxt;
  logic                        repeat_r, repeat_nxt;

  bclpr_pkg::time_t            now_t;
  bclpr_pkg::time_t            win_elapsed;
  bclpr_pkg::time_t            hold_elapsed;
  logic                        click_fin;
  logic [bclpr_pkg::CNT_W-1:0] presses_a;
  logic [bclpr_pkg::CNT_W-1:0] total;
  logic                        changed;

  always_comb begin
    now_t            = bclpr_pkg::to_time(smp.now_ms);
    win_elapsed      = now_t - window_start_r;
    hold_elapsed     = now_t - hold_start_r;
    last_level_nxt   = last_level_r;
    hold_start_nxt   = hold_start_r;
    window_start_nxt = window_start_r;
    presses_nxt      = presses_r;
    long_nxt         = long_r;
    repeat_nxt       = repeat_r;
    click_fin        = 1'b0;
    presses_a        = presses_r;
    total            = '0;
    changed          = 1'b0;
    if (cfg.enabled) begin
      last_level_nxt = smp.level;
      click_fin = (presses_r != '0) && bclpr_pkg::exceeds(win_elapsed, cfg.click_window_ms);
      if (click_fin) begin
        total     = presses_r;
        presses_a = '0;
        changed   = 1'b1;
      end
      presses_nxt = presses_a;
      if (smp.level) begin
        hold_start_nxt = '0;
        long_nxt       = 1'b0;
        repeat_nxt     = 1'b0;
        if (!last_level_r) begin
          changed = 1'b1;
        end
      end else if (last_level_r) begin
        hold_start_nxt = now_t;
        if (presses_a != bclpr_pkg::PRESS_MAX) begin
          presses_nxt = presses_a + 1'b1;
        end
        if (presses_nxt == {{(bclpr_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
          window_start_nxt = now_t;
        end
        changed = 1'b1;
      end else if (!long_r) begin
        if (bclpr_pkg::exceeds(hold_elapsed, cfg.long_press_ms)) begin
          long_nxt       = 1'b1;
          hold_start_nxt = now_t;
          changed        = 1'b1;
        end
      end else if (bclpr_pkg::exceeds(hold_elapsed, cfg.repeat_ms)) begin
        repeat_nxt     = 1'b1;
        hold_start_nxt = now_t;
        changed        = 1'b1;
      end
    end
    res.changed     = changed;
    res.pressed     = ~last_level_nxt;
    res.press_count = presses_nxt;
    res.click_total = total;
    res.long_flag   = long_nxt;
    res.repeat_flag = repeat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b1;
      hold_start_r   <= '0;
      window_start_r <= '0;
      presses_r      <= '0;
      long_r         <= 1'b0;
      repeat_r       <= 1'b0;
    end else if (fire) begin
      last_level_r   <= last_level_nxt;
      hold_start_r   <= hold_start_nxt;
      window_start_r <= window_start_nxt;
      presses_r      <= presses_nxt;
      long_r         <= long_nxt;
      repeat_r       <= repeat_nxt;
    end
  end

endmodule

`default_nettype wire

/* dv/button_click_long_press_repeat_tb.sv */
// Self-checking testbench for the button multi-click, long-press and repeat detector.
// It predicts every result in the testbench and checks the result stream field by field.
// It depends on bclpr_pkg and the button_click_long_press_repeat top level.
`timescale 1ns / 1ps

module button_click_long_press_repeat_tb;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_level  = 1'b1;
  logic [31:0]                     in_now_ms = '0;
  logic                            out_stall = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [bclpr_pkg::CFG_IDX_W-1:0] cfg_index = bclpr_pkg::REG_ENABLED;
  logic [15:0]                     cfg_data  = '0;
  wire logic                       in_stall;
  wire logic                       out_valid;
  wire logic                       out_changed;
  wire logic                       out_pressed;
  wire logic [7:0]                 out_press_count;
  wire logic [7:0]                 out_click_total;
  wire logic                       out_long_flag;
  wire logic                       out_repeat_flag;
  wire logic                       cfg_ready;

  button_click_long_press_repeat dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_level        (in_level),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_changed     (out_changed),
    .out_pressed     (out_pressed),
    .out_press_count (out_press_count),
    .out_click_total (out_click_total),
    .out_long_flag   (out_long_flag),
    .out_repeat_flag (out_repeat_flag),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  logic                        m_enabled      = 1'b1;
  logic [bclpr_pkg::THR_W-1:0] m_click_window = bclpr_pkg::CLICK_WINDOW_RST;
  logic [bclpr_pkg::THR_W-1:0] m_long_ms      = bclpr_pkg::LONG_PRESS_RST;
  logic [bclpr_pkg::THR_W-1:0] m_repeat_ms    = bclpr_pkg::REPEAT_RST;

  logic                        m_last_level   = 1'b1;
  bclpr_pkg::time_t            m_hold_start   = '0;
  bclpr_pkg::time_t            m_window_start = '0;
  logic [bclpr_pkg::CNT_W-1:0] m_presses      = '0;
  logic [bclpr_pkg::CNT_W-1:0] m_clicks_done  = '0;
  logic                        m_long         = 1'b0;
  logic                        m_repeat       = 1'b0;

  bclpr_pkg::sample_t samples_q[$];
  bclpr_pkg::result_t predicted_q[$];
  bclpr_pkg::sample_t tx_req;
  bclpr_pkg::result_t want;
  bclpr_pkg::time_t   t_ms       = '0;
  int unsigned        n_queued   = 0;
  int unsigned        send_gap   = 0;
  int unsigned        stall_left = 0;
  int unsigned        mismatches = 0;
  bit                 tx_idle    = 1'b1;
  bit                 rx_idle    = 1'b1;

  initial forever #4 clk = ~clk;

  function automatic bclpr_pkg::result_t predict_button(logic lvl, bclpr_pkg::time_t now);
    bclpr_pkg::result_t r;
    logic               prev;
    r = '0;
    if (m_enabled) begin
      prev = m_last_level;
      m_last_level = lvl;
      m_clicks_done = '0;
      if (m_presses != '0 && bclpr_pkg::time_t'(now - m_window_start) >
          bclpr_pkg::time_t'(m_click_window)) begin
        m_clicks_done = m_presses;
        m_presses = '0;
        r.changed = 1'b1;
      end
      if (lvl) begin
        m_hold_start = '0;
        m_long = 1'b0;
        m_repeat = 1'b0;
        if (!prev) r.changed = 1'b1;
      end else if (prev) begin
        m_hold_start = now;
        if (m_presses != bclpr_pkg::PRESS_MAX) m_presses = m_presses + 1'b1;
        if (m_presses == 8'd1) m_window_start = now;
        r.changed = 1'b1;
      end else if (!m_long) begin
        if (bclpr_pkg::time_t'(now - m_hold_start) > bclpr_pkg::time_t'(m_long_ms)) begin
          m_long = 1'b1;
          m_hold_start = now;
          r.changed = 1'b1;
        end
      end else if (bclpr_pkg::time_t'(now - m_hold_start) > bclpr_pkg::time_t'(m_repeat_ms)) begin
        m_repeat = 1'b1;
        m_hold_start = now;
        r.changed = 1'b1;
      end
      r.click_total = m_clicks_done;
    end
    r.pressed     = ~m_last_level;
    r.press_count = m_presses;
    r.long_flag   = m_long;
    r.repeat_flag = m_repeat;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // Sender: a request stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) predicted_q.push_back(predict_button(in_level, in_now_ms));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (samples_q.size() != 0) begin
          tx_req = samples_q.pop_front();
          in_valid  <= 1'b1;
          in_level  <= tx_req.level;
          in_now_ms <= tx_req.now_ms;
          send_gap = pick_gap(tx_idle);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall stretches and the result check.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, expected none, actual changed=%0d",
                   $time, out_changed);
        end else begin
          want = predicted_q.pop_front();
          check_field("changed", want.changed, out_changed);
          check_field("pressed", want.pressed, out_pressed);
          check_field("press_count", want.press_count, out_press_count);
          check_field("click_total", want.click_total, out_click_total);
          check_field("long_flag", want.long_flag, out_long_flag);
          check_field("repeat_flag", want.repeat_flag, out_repeat_flag);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(rx_idle);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_sample(logic lvl, bclpr_pkg::time_t t);
    bclpr_pkg::sample_t s;
    s.level  = lvl;
    s.now_ms = t;
    samples_q.push_back(s);
    n_queued++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (samples_q.size() != 0 || in_valid || predicted_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(bclpr_pkg::cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bclpr_pkg::REG_ENABLED:      m_enabled      = val[0];
      bclpr_pkg::REG_CLICK_WINDOW: m_click_window = val;
      bclpr_pkg::REG_LONG_PRESS:   m_long_ms      = val;
      bclpr_pkg::REG_REPEAT:       m_repeat_ms    = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic en, logic [15:0] win, logic [15:0] lng, logic [15:0] rep);
    write_reg(bclpr_pkg::REG_ENABLED, {15'd0, en});
    write_reg(bclpr_pkg::REG_CLICK_WINDOW, win);
    write_reg(bclpr_pkg::REG_LONG_PRESS, lng);
    write_reg(bclpr_pkg::REG_REPEAT, rep);
  endtask

  task automatic taps(int unsigned n);
    int unsigned step_max;
    step_max = m_click_window / (4 * n) + 1;
    repeat (n) begin
      queue_sample(1'b0, t_ms);
      if ($urandom_range(0, 2) == 0) begin
        t_ms += $urandom_range(0, step_max);
        queue_sample(1'b0, t_ms);
      end
      t_ms += $urandom_range(0, step_max);
      queue_sample(1'b1, t_ms);
      t_ms += $urandom_range(0, step_max);
    end
    t_ms += m_click_window + $urandom_range(0, 2);
    queue_sample(1'b1, t_ms);
  endtask

  task automatic hold_press(int unsigned reps);
    queue_sample(1'b0, t_ms);
    t_ms += m_long_ms + $urandom_range(0, 2);
    queue_sample(1'b0, t_ms);
    repeat (reps) begin
      t_ms += m_repeat_ms + $urandom_range(0, 2);
      queue_sample(1'b0, t_ms);
    end
    t_ms += $urandom_range(0, 50);
    queue_sample(1'b1, t_ms);
  endtask

  task automatic noise(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) t_ms = $urandom;
      else if (r == 1) t_ms -= $urandom_range(1, 1000);
      else t_ms += $urandom_range(0, 200);
      queue_sample(1'($urandom_range(0, 1)), t_ms);
    end
  endtask

  task automatic random_traffic(int unsigned target);
    int unsigned first;
    int unsigned r;
    first = n_queued;
    while (n_queued - first < target) begin
      if ($urandom_range(0, 9) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      r = $urandom_range(0, 9);
      if (r < 4) taps($urandom_range(1, 4));
      else if (r < 7) hold_press($urandom_range(0, 4));
      else noise($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: long press, repeats, a triple click and a press across the wrap.
    queue_sample(1'b1, 32'd0);
    queue_sample(1'b0, 32'd10);
    queue_sample(1'b0, 32'd500);
    queue_sample(1'b0, 32'd1010);
    queue_sample(1'b0, 32'd1011);
    queue_sample(1'b0, 32'd1111);
    queue_sample(1'b0, 32'd1112);
    queue_sample(1'b0, 32'd1213);
    queue_sample(1'b1, 32'd1250);
    queue_sample(1'b0, 32'd2000);
    queue_sample(1'b1, 32'd2040);
    queue_sample(1'b0, 32'd2080);
    queue_sample(1'b1, 32'd2120);
    queue_sample(1'b0, 32'd2160);
    queue_sample(1'b1, 32'd2200);
    queue_sample(1'b1, 32'd2300);
    queue_sample(1'b1, 32'd2301);
    queue_sample(1'b0, 32'hFFFF_FFF0);
    queue_sample(1'b1, 32'h0000_0020);
    queue_sample(1'b1, 32'h0000_0120);
    queue_sample(1'b0, 32'h0000_0130);
    queue_sample(1'b0, 32'h0000_0130);
    queue_sample(1'b0, 32'h0000_0519);
    queue_sample(1'b1, 32'h0000_0519);
    queue_sample(1'b1, 32'hFFFF_FFFF);
    t_ms = 32'd5000;
    drain();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_config(1'b1, 16'd0, 16'd0, 16'd0);
    random_traffic(70);
    drain();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_traffic(70);
    queue_sample(1'b0, t_ms);
    drain();

    // While disabled the held press must survive untouched.
    write_reg(bclpr_pkg::REG_ENABLED, 16'd0);
    noise(30);
    hold_press(1);
    drain();

    // Enough fast taps in one window to saturate the press count.
    set_config(1'b1, 16'hFFFF, 16'd500, 16'd50);
    taps(258);
    drain();

    repeat (2) begin
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle = 1'($urandom_range(0, 1));
      set_config(1'b1, 16'($urandom_range(20, 400)), 16'($urandom_range(50, 1500)),
                 16'($urandom_range(10, 200)));
      random_traffic(70);
      drain();
    end

    if (mismatches == 0) begin
      $display("button_click_long_press_repeat_tb: clean");
    end else begin
      $display("button_click_long_press_repeat_tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("button_click_long_press_repeat_tb: errors");
    $finish;
  end

endmodule
